// ----- rtl/core/pcs_active_reactive_dispatch_macros.svh -----
// Assertion macros for the power dispatch block.
// Used by the checker module; needs nothing else.
`ifndef PCS_ACTIVE_REACTIVE_DISPATCH_MACROS_SVH
`define PCS_ACTIVE_REACTIVE_DISPATCH_MACROS_SVH

// check a property on every clock edge, quiet while reset is asserted
`define PCS_ARD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

// check a property on every clock edge, reset included
`define PCS_ARD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: property failed");

`endif

// ----- rtl/core/pcs_ard_pkg.sv -----
// Shared types and constants for the power dispatch block.
// No dependencies; used by the top level and the checker.
package pcs_ard_pkg;

	localparam int unsigned COEF_W     = 17;
	localparam int unsigned CFG_ADDR_W = 3;

	localparam logic [CFG_ADDR_W-1:0] CFG_G1_DIS  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_G1_CHG  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_G2_DIS  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_G2_CHG  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SD_MODE = 3'd4;

	// root bits of sqrt((S^2 - P^2) * 2^16) for S below 2^15
	localparam int unsigned SQ_RES_W = 23;

	// edges from accepting an item to the edge that takes its result
	localparam int unsigned PIPE_LAT = 31;

	typedef struct packed {
		logic signed [15:0] total_q_target;
		logic signed [15:0] group1_p_total;
		logic signed [15:0] group2_p_total;
		logic [15:0]        pcs1_status;
		logic [15:0]        pcs2_status;
		logic [15:0]        pcs3_status;
		logic [15:0]        pcs4_status;
	} dsp_in_t;

	typedef struct packed {
		logic signed [15:0] pcs1_p_cmd;
		logic signed [15:0] pcs2_p_cmd;
		logic signed [15:0] pcs3_p_cmd;
		logic signed [15:0] pcs4_p_cmd;
		logic [15:0]        group1_q_capacity;
		logic [15:0]        group2_q_capacity;
		logic [1:0]         group1_avail_count;
		logic [1:0]         group2_avail_count;
		logic [15:0]        balanced_q_capacity;
		logic [15:0]        plant_q_capacity;
		logic signed [15:0] group1_q_set;
		logic signed [15:0] group2_q_set;
	} dsp_out_t;

endpackage

// ----- rtl/core/pcs_ard_isqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
// Standalone; instanced by the dispatch top level.
module pcs_ard_isqrt #(
	parameter int unsigned N = 23
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [2*N-1:0] radicand,
	output logic           out_valid,
	output logic [N-1:0]   root
);

	logic           v_s    [0:N];
	logic [N+1:0]   rem_s  [0:N];
	logic [N-1:0]   root_s [0:N];
	logic [2*N-1:0] rad_s  [0:N];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [N+1:0] rem_sh;
		logic [N+1:0] trial;

		// bring down the next two radicand bits, try a one in the root
		assign rem_sh = {rem_s[k-1][N-1:0], rad_s[k-1][2*N-1 -: 2]};
		assign trial  = {root_s[k-1], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_sh >= trial) begin
				rem_s[k]  <= rem_sh - trial;
				root_s[k] <= {root_s[k-1][N-2:0], 1'b1};
			end else begin
				rem_s[k]  <= rem_sh;
				root_s[k] <= {root_s[k-1][N-2:0], 1'b0};
			end
			rad_s[k] <= {rad_s[k-1][2*N-3:0], 2'b00};
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];

endmodule

// ----- rtl/core/pcs_active_reactive_dispatch.sv -----
// Active/reactive power dispatch, pipelined from start to done.
// Throughput one item per cycle; busy is never raised and results cannot stall.
// The 23-stage square root pipeline sets most of the latency.
// Asynchronous reset clears the configuration registers and every valid bit.
// Depends on pcs_ard_pkg and pcs_ard_isqrt.
module pcs_active_reactive_dispatch #(
	parameter int unsigned COEF_BASE      = 1000,
	parameter int unsigned RATED_FULL_KVA = 2500,
	parameter int unsigned RATED_HALF_KVA = 1250
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcs_ard_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pcs_ard_pkg::COEF_W-1:0]      cfg_wdata,
	input  logic                                start,
	input  pcs_ard_pkg::dsp_in_t                item,
	output logic                                busy,
	output logic                                done,
	output pcs_ard_pkg::dsp_out_t               result
);
	import pcs_ard_pkg::*;

	localparam int unsigned CW = $clog2(COEF_BASE + 1);
	localparam int unsigned XW = 16 + CW;
	localparam logic [31:0] RECIP = 32'(64'd4294967295 / COEF_BASE);
	localparam logic [29:0] FULL_SQ = 30'(RATED_FULL_KVA * RATED_FULL_KVA);
	localparam logic [29:0] HALF_SQ = 30'(RATED_HALF_KVA * RATED_HALF_KVA);

	typedef struct packed {
		logic [3:0][15:0]   pc;
		logic signed [15:0] tq;
		logic [1:0]         a1;
		logic [1:0]         a2;
	} side_t;

	function automatic logic [14:0] rating(input logic [1:0] run);
		case (run)
			2'b11:        return 15'(RATED_FULL_KVA);
			2'b01, 2'b10: return 15'(RATED_HALF_KVA);
			default:      return 15'd0;
		endcase
	endfunction

	function automatic logic [29:0] rating_sq(input logic [1:0] run);
		case (run)
			2'b11:        return FULL_SQ;
			2'b01, 2'b10: return HALF_SQ;
			default:      return 30'd0;
		endcase
	endfunction

	function automatic logic signed [26:0] lim(input logic signed [26:0] q,
			input logic signed [26:0] m);
		if (m <= 0) return '0;
		if (q > m) return m;
		if (q < -m) return -m;
		return q;
	endfunction

	// truncate toward zero, then saturate to 16 bits signed
	function automatic logic [15:0] q8_s16(input logic signed [26:0] v);
		logic [26:0] mag;
		logic [18:0] i;
		mag = v[26] ? 27'(-v) : 27'(v);
		i   = mag[26:8];
		if (v[26]) begin
			if (i > 19'd32768) return 16'h8000;
			return 16'(~i + 19'd1);
		end
		if (i > 19'd32767) return 16'h7fff;
		return i[15:0];
	endfunction

	// configuration registers
	logic [COEF_W-1:0] g1_dis_q, g1_chg_q, g2_dis_q, g2_chg_q;
	logic              sd_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_dis_q  <= '0;
			g1_chg_q  <= '0;
			g2_dis_q  <= '0;
			g2_chg_q  <= '0;
			sd_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_G1_DIS:  g1_dis_q  <= cfg_wdata;
				CFG_G1_CHG:  g1_chg_q  <= cfg_wdata;
				CFG_G2_DIS:  g2_dis_q  <= cfg_wdata;
				CFG_G2_CHG:  g2_chg_q  <= cfg_wdata;
				CFG_SD_MODE: sd_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [3:0] sq_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= &sq_v;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// stage 1: magnitude, sign and clamped coefficient per group
	logic [15:0]        pa_c  [2];
	logic               neg_c [2];
	logic [CW-1:0]      c_c   [2];
	logic signed [15:0] p_c   [2];
	logic [COEF_W-1:0]  sel_c [2];

	always_comb begin
		p_c[0] = item.group1_p_total;
		p_c[1] = item.group2_p_total;
		for (int g = 0; g < 2; g++) begin
			neg_c[g] = p_c[g][15];
			pa_c[g]  = neg_c[g] ? 16'(-p_c[g]) : 16'(p_c[g]);
			if (!neg_c[g] && p_c[g] != 16'sd0) begin
				sel_c[g] = (g == 0) ? g1_dis_q : g2_dis_q;
			end else begin
				sel_c[g] = (g == 0) ? g1_chg_q : g2_chg_q;
			end
			c_c[g] = (sel_c[g] > COEF_W'(COEF_BASE)) ? CW'(COEF_BASE) : CW'(sel_c[g]);
		end
	end

	logic [15:0]        pa_s1  [2];
	logic               neg_s1 [2], neg_s2 [2], neg_s3 [2];
	logic [CW-1:0]      c_s1   [2];
	logic signed [15:0] p_s1   [2], p_s2 [2], p_s3 [2];
	logic signed [15:0] tq_s1, tq_s2, tq_s3, tq_s4, tq_s5;
	logic [3:0][1:0]    run_s1, run_s2, run_s3, run_s4;
	logic [XW-1:0]      x_s2   [2], x_s3 [2];
	logic [15:0]        q0_s3  [2];
	logic [XW+31:0]     prod_c [2];
	logic [XW-1:0]      r_c    [2];
	logic [15:0]        mag_c  [2];
	logic signed [15:0] m_c    [2];
	logic [3:0][15:0]   pc_s4, pc_s5;
	logic [15:0]        abs_c  [4];
	logic [31:0]        pa2_s5 [4];
	logic               ok_s5  [4];
	logic [29:0]        ssq_s5 [4];
	logic [1:0]         a1_s5, a2_s5;

	always_ff @(posedge clk) begin
		for (int g = 0; g < 2; g++) begin
			pa_s1[g]  <= pa_c[g];
			neg_s1[g] <= neg_c[g];
			c_s1[g]   <= c_c[g];
			p_s1[g]   <= p_c[g];
		end
		tq_s1  <= item.total_q_target;
		run_s1 <= {item.pcs4_status[9:8], item.pcs3_status[9:8],
			item.pcs2_status[9:8], item.pcs1_status[9:8]};
	end

	// stage 2: |p| * coef
	always_ff @(posedge clk) begin
		for (int g = 0; g < 2; g++) begin
			x_s2[g]   <= XW'(pa_s1[g]) * XW'(c_s1[g]);
			neg_s2[g] <= neg_s1[g];
			p_s2[g]   <= p_s1[g];
		end
		tq_s2  <= tq_s1;
		run_s2 <= run_s1;
	end

	// stage 3: quotient estimate by reciprocal, low by at most one
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			prod_c[g] = (XW+32)'(x_s2[g]) * (XW+32)'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 2; g++) begin
			q0_s3[g]  <= prod_c[g][32 +: 16];
			x_s3[g]   <= x_s2[g];
			neg_s3[g] <= neg_s2[g];
			p_s3[g]   <= p_s2[g];
		end
		tq_s3  <= tq_s2;
		run_s3 <= run_s2;
	end

	// stage 4: correct the quotient, split master and slave
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			r_c[g]   = x_s3[g] - XW'(q0_s3[g]) * XW'(COEF_BASE);
			mag_c[g] = q0_s3[g] + 16'(r_c[g] >= XW'(COEF_BASE));
			m_c[g]   = neg_s3[g] ? -$signed(mag_c[g]) : $signed(mag_c[g]);
		end
	end

	always_ff @(posedge clk) begin
		pc_s4[0] <= m_c[0];
		pc_s4[1] <= p_s3[0] - m_c[0];
		pc_s4[2] <= m_c[1];
		pc_s4[3] <= p_s3[1] - m_c[1];
		tq_s4    <= tq_s3;
		run_s4   <= run_s3;
	end

	// stage 5: P^2 and the rating check
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			abs_c[i] = pc_s4[i][15] ? 16'(-$signed(pc_s4[i])) : pc_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pa2_s5[i] <= 32'(abs_c[i]) * 32'(abs_c[i]);
			ok_s5[i]  <= abs_c[i] < 16'(rating(run_s4[i]));
			ssq_s5[i] <= rating_sq(run_s4[i]);
		end
		pc_s5 <= pc_s4;
		tq_s5 <= tq_s4;
		a1_s5 <= 2'(|run_s4[0]) + 2'(|run_s4[1]);
		a2_s5 <= 2'(|run_s4[2]) + 2'(|run_s4[3]);
	end

	// square root per converter, side fields delayed alongside
	logic [SQ_RES_W-1:0] root_c [4];

	for (genvar i = 0; i < 4; i++) begin : g_sqrt
		logic [2*SQ_RES_W-1:0] rad;
		assign rad = ok_s5[i] ?
			{(2*SQ_RES_W-16)'(ssq_s5[i] - pa2_s5[i][29:0]), 16'd0} : '0;

		pcs_ard_isqrt #(
			.N(SQ_RES_W)
		) u_isqrt (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_s5),
			.radicand (rad),
			.out_valid(sq_v[i]),
			.root     (root_c[i])
		);
	end

	side_t side_s5;
	side_t side_d [0:SQ_RES_W-1];

	assign side_s5 = '{pc: pc_s5, tq: tq_s5, a1: a1_s5, a2: a2_s5};

	always_ff @(posedge clk) begin
		side_d[0] <= side_s5;
		for (int k = 1; k < SQ_RES_W; k++) begin
			side_d[k] <= side_d[k-1];
		end
	end

	// stage 6: group capabilities
	logic [SQ_RES_W:0] g1_s6, g2_s6, g1_s7, g2_s7;
	side_t             side_s6, side_s7;

	always_ff @(posedge clk) begin
		g1_s6   <= (SQ_RES_W+1)'(root_c[0]) + (SQ_RES_W+1)'(root_c[1]);
		g2_s6   <= (SQ_RES_W+1)'(root_c[2]) + (SQ_RES_W+1)'(root_c[3]);
		side_s6 <= side_d[SQ_RES_W-1];
	end

	// stage 7: balance and limited half target
	logic [SQ_RES_W:0]     bal_c, bal_s7;
	logic signed [26:0]    tgt_s7;

	assign bal_c = (g1_s6 < g2_s6) ? g1_s6 : g2_s6;

	always_ff @(posedge clk) begin
		bal_s7  <= bal_c;
		tgt_s7  <= lim(27'($signed({side_s6.tq, 7'd0})), $signed(27'(bal_c)));
		g1_s7   <= g1_s6;
		g2_s7   <= g2_s6;
		side_s7 <= side_s6;
	end

	// result register
	logic signed [26:0] gq_c [2];
	logic [SQ_RES_W:0]  gm_c [2];
	logic [1:0]         ga_c [2];
	logic [16:0]        plant_c;
	logic               none_c;

	always_comb begin
		gm_c[0] = g1_s7;
		gm_c[1] = g2_s7;
		ga_c[0] = side_s7.a1;
		ga_c[1] = side_s7.a2;
		for (int g = 0; g < 2; g++) begin
			if (sd_mode_q && ga_c[g] == 2'd1) begin
				gq_c[g] = lim(tgt_s7 <<< 1, $signed(27'(gm_c[g])) <<< 1);
			end else begin
				gq_c[g] = lim(tgt_s7, $signed(27'(gm_c[g])));
			end
		end
		plant_c = bal_s7[SQ_RES_W:7];
		none_c  = side_s7.a1 == 2'd0 || side_s7.a2 == 2'd0;
	end

	always_ff @(posedge clk) begin
		result.pcs1_p_cmd          <= side_s7.pc[0];
		result.pcs2_p_cmd          <= side_s7.pc[1];
		result.pcs3_p_cmd          <= side_s7.pc[2];
		result.pcs4_p_cmd          <= side_s7.pc[3];
		result.group1_q_capacity   <= g1_s7[SQ_RES_W:8];
		result.group2_q_capacity   <= g2_s7[SQ_RES_W:8];
		result.group1_avail_count  <= side_s7.a1;
		result.group2_avail_count  <= side_s7.a2;
		if (none_c) begin
			result.balanced_q_capacity <= '0;
			result.plant_q_capacity    <= '0;
			result.group1_q_set        <= '0;
			result.group2_q_set        <= '0;
		end else begin
			result.balanced_q_capacity <= bal_s7[SQ_RES_W:8];
			result.plant_q_capacity    <= plant_c[16] ? 16'hffff : plant_c[15:0];
			result.group1_q_set        <= q8_s16(gq_c[0]);
			result.group2_q_set        <= q8_s16(gq_c[1]);
		end
	end

endmodule

// ----- rtl/core/pcs_ard_checker.sv -----
// Port-level checker for the power dispatch block, bound to its top level.
// Depends on pcs_ard_pkg and pcs_active_reactive_dispatch_macros.svh.
`include "pcs_active_reactive_dispatch_macros.svh"

module pcs_ard_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input pcs_ard_pkg::dsp_out_t              result
);
	import pcs_ard_pkg::*;

	// the pipeline never holds off an item
	`PCS_ARD_ASSERT_ALWAYS(a_never_busy, clk, !busy)

	// every result comes from an item taken a fixed time earlier
	`PCS_ARD_ASSERT(a_done_latency, clk, arst_n, done |-> $past(start && !busy, PIPE_LAT))

	// no reactive share when a group has no converter
	`PCS_ARD_ASSERT(a_empty_group, clk, arst_n, done && (result.group1_avail_count == 2'd0 || result.group2_avail_count == 2'd0) |-> result.balanced_q_capacity == 16'd0 && result.plant_q_capacity == 16'd0 && result.group1_q_set == 16'sd0 && result.group2_q_set == 16'sd0)

	// plant figure is at least the balance, counts stay within two
	`PCS_ARD_ASSERT(a_plant_bal, clk, arst_n, done |-> result.plant_q_capacity >= result.balanced_q_capacity && result.group1_avail_count != 2'd3 && result.group2_avail_count != 2'd3)

endmodule

bind pcs_active_reactive_dispatch pcs_ard_checker u_pcs_ard_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
